// ===== hw/rtl/mlp_pkg.sv =====
// ---------------------------------------------------------------------------
// mlp_pkg
// Shared types and constants of the manifest line parser: parse phases,
// sequencer states, status codes and the line verdict record.
// ---------------------------------------------------------------------------
`default_nettype none

package mlp_pkg;

   localparam int PATH_BYTES_DEF = 64;

   localparam logic [1:0] ST_VALID     = 2'd0;
   localparam logic [1:0] ST_BLANK     = 2'd1;
   localparam logic [1:0] ST_MALFORMED = 2'd2;

   localparam logic [3:0] HEX_DIGITS = 4'd8;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_DASH  = 8'h2d;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_SEMI  = 8'h3b;
   localparam logic [7:0] CH_EQUAL = 8'h3d;
   localparam logic [7:0] CH_UNDER = 8'h5f;

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_BLANK,
      PH_PATH,
      PH_HEXLEAD,
      PH_HEX,
      PH_TAIL,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      CTL_PARSE,
      CTL_REPLAY,
      CTL_FINAL
   } ctl_state_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] checksum;
   } verdict_type;

endpackage

`default_nettype wire

// ===== hw/rtl/mlp_channel_if.sv =====
// ---------------------------------------------------------------------------
// mlp_channel_if
// Valid/ready channels of the manifest line parser: byte input and result
// output.
// ---------------------------------------------------------------------------
`default_nettype none

interface mlp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] line_byte;
   logic       line_end;

   modport source (output valid, output line_byte, output line_end, input ready);
   modport sink   (input valid, input line_byte, input line_end, output ready);
endinterface

interface mlp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  path_char;
   logic [1:0]  status;
   logic [31:0] checksum_value;
   logic [5:0]  path_length;
   logic        final_flag;

   modport source (output valid, output path_char, output status, output checksum_value,
                   output path_length, output final_flag, input ready);
   modport sink   (input valid, input path_char, input status, input checksum_value,
                   input path_length, input final_flag, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mlp_byte_parser.sv =====
// ---------------------------------------------------------------------------
// mlp_byte_parser
// Per-byte parse of one manifest line: phase tracking, path checks, path
// store writes and the hex field; gives the verdict of the line at its last
// byte.
// ---------------------------------------------------------------------------
`default_nettype none

module mlp_byte_parser
   import mlp_pkg::*;
#(
   parameter int PATH_BYTES = PATH_BYTES_DEF,
   localparam int AW = $clog2(PATH_BYTES)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  wire logic [7:0]    line_byte,
   input  wire logic          line_end,
   output logic               path_wr_en,
   output logic [AW-1:0]      path_wr_idx,
   output logic [7:0]         path_wr_byte,
   output verdict_type        verdict,
   output logic [AW-1:0]      verdict_count
);

   localparam logic [AW-1:0] COUNT_LIMIT = AW'(PATH_BYTES - 1);

   phase_type     phase_ff, phase_in;
   logic [AW-1:0] count_ff, count_in;
   logic [31:0]   acc_ff, acc_in;
   logic [3:0]    digits_ff, digits_in;
   logic          dot_ff, dot_in;
   logic          tblank_ff, tblank_in;
   logic          err_ff, err_in;

   logic          do_path;
   logic          do_hex;
   logic          wr_en;
   logic          is_blank;
   logic          is_eol;
   logic [4:0]    nib;

   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
      return r;
   endfunction

   function automatic logic path_char_ok(input logic [7:0] c);
      logic ok;
      ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a) || c == CH_UNDER || c == CH_DASH ||
           c == CH_SLASH || c == CH_DOT;
      return ok;
   endfunction

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      acc_in    = acc_ff;
      digits_in = digits_ff;
      dot_in    = dot_ff;
      tblank_in = tblank_ff;
      err_in    = err_ff;
      do_path   = 1'b0;
      do_hex    = 1'b0;
      wr_en     = 1'b0;
      is_blank  = (line_byte == CH_SPACE) || (line_byte == CH_TAB);
      is_eol    = (line_byte == CH_NUL) || (line_byte == CH_CR) || (line_byte == CH_LF);
      nib       = hex_nibble(line_byte);

      case (phase_ff)
         PH_LEAD: begin
            if (is_blank || line_byte == CH_CR || line_byte == CH_LF) begin
               phase_in = PH_LEAD;
            end else if (line_byte == CH_NUL || line_byte == CH_HASH ||
                         line_byte == CH_SEMI) begin
               phase_in = PH_BLANK;
            end else if (line_byte == CH_EQUAL) begin
               phase_in = PH_DONE;
               err_in   = 1'b1;
            end else begin
               phase_in = PH_PATH;
               do_path  = 1'b1;
            end
         end
         PH_PATH:    do_path = 1'b1;
         PH_HEXLEAD: do_hex  = !is_blank;
         PH_HEX:     do_hex  = 1'b1;
         PH_TAIL: begin
            if (is_eol) begin
               phase_in = PH_DONE;
            end else if (!is_blank) begin
               phase_in = PH_DONE;
               err_in   = 1'b1;
            end
         end
         default: phase_in = phase_ff;
      endcase

      if (do_path) begin
         if (line_byte == CH_EQUAL) begin
            phase_in = PH_HEXLEAD;
         end else if (line_byte == CH_NUL || (!is_blank && tblank_ff) ||
                      (!is_blank && !path_char_ok(line_byte)) ||
                      (line_byte == CH_SLASH && count_ff == '0) ||
                      (line_byte == CH_DOT && dot_ff) ||
                      (!is_blank && count_ff >= COUNT_LIMIT)) begin
            phase_in = PH_DONE;
            err_in   = 1'b1;
         end else if (is_blank) begin
            tblank_in = 1'b1;
         end else begin
            wr_en    = 1'b1;
            count_in = count_ff + 1'b1;
            dot_in   = (line_byte == CH_DOT);
         end
      end

      if (do_hex) begin
         if (is_eol || is_blank) begin
            if (digits_ff != HEX_DIGITS) begin
               phase_in = PH_DONE;
               err_in   = 1'b1;
            end else begin
               phase_in = is_eol ? PH_DONE : PH_TAIL;
            end
         end else if (!nib[4] || digits_ff >= HEX_DIGITS) begin
            phase_in = PH_DONE;
            err_in   = 1'b1;
         end else begin
            acc_in    = {acc_ff[27:0], nib[3:0]};
            digits_in = digits_ff + 4'd1;
            phase_in  = PH_HEX;
         end
      end

      // verdict as the line stands after this byte
      case (phase_in)
         PH_LEAD, PH_BLANK:  verdict.status = ST_BLANK;
         PH_HEXLEAD, PH_HEX: verdict.status = (digits_in == HEX_DIGITS) ? ST_VALID
                                                                        : ST_MALFORMED;
         PH_TAIL:            verdict.status = ST_VALID;
         PH_DONE:            verdict.status = err_in ? ST_MALFORMED : ST_VALID;
         default:            verdict.status = ST_MALFORMED;
      endcase
      verdict.checksum = acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && line_end)) begin
         phase_ff  <= PH_LEAD;
         count_ff  <= '0;
         acc_ff    <= '0;
         digits_ff <= '0;
         dot_ff    <= 1'b0;
         tblank_ff <= 1'b0;
         err_ff    <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         acc_ff    <= acc_in;
         digits_ff <= digits_in;
         dot_ff    <= dot_in;
         tblank_ff <= tblank_in;
         err_ff    <= err_in;
      end
   end

   assign path_wr_en    = step && wr_en;
   assign path_wr_idx   = count_ff;
   assign path_wr_byte  = line_byte;
   assign verdict_count = count_in;

endmodule

`default_nettype wire

// ===== hw/rtl/manifest_line_parser_unit.sv =====
// Timing: a line without path output gives its final beat in the cycle after its last byte;
// for a valid line the first path byte passes the sequencer state, the memory read register
// and the output register; path bytes and the final beat then follow one per cycle while the
// sink takes them. Throughput: one input byte per cycle while no replay runs and the output
// is free; a replay on the single memory read port holds the input up to its final beat.
// Reset: synchronous; clears the parse state and sequencer, path memory is left as is.
// ---------------------------------------------------------------------------
// manifest_line_parser_unit
// Checks manifest lines of the form path=HHHHHHHH byte by byte, keeps the
// path in a memory and replays it ahead of the final status beat.
// ---------------------------------------------------------------------------
`default_nettype none

module manifest_line_parser_unit
   import mlp_pkg::*;
#(
   parameter int PATH_BYTES = PATH_BYTES_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mlp_req_if.sink    req_chan,
   mlp_rsp_if.source  rsp_chan
);

   localparam int AW = $clog2(PATH_BYTES);

   logic [7:0]    path_mem [PATH_BYTES];

   ctl_state_type ctl_state_ff, ctl_state_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic          rd_pend_ff, rd_pend_in;
   logic [7:0]    rd_data_ff;
   logic [31:0]   fin_sum_ff;
   logic [AW-1:0] fin_cnt_ff;

   logic          out_valid_ff;
   logic [7:0]    out_char_ff;
   logic [1:0]    out_status_ff;
   logic [31:0]   out_sum_ff;
   logic [5:0]    out_len_ff;
   logic          out_final_ff;

   logic          out_free;
   logic          accept;
   logic          start_replay;
   logic          load_direct;
   logic          load_byte;
   logic          load_final;
   logic          issue;

   logic          path_wr_en;
   logic [AW-1:0] path_wr_idx;
   logic [7:0]    path_wr_byte;
   verdict_type   verdict;
   logic [AW-1:0] verdict_count;

   mlp_byte_parser #(
      .PATH_BYTES (PATH_BYTES)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (accept),
      .line_byte     (req_chan.line_byte),
      .line_end      (req_chan.line_end),
      .path_wr_en    (path_wr_en),
      .path_wr_idx   (path_wr_idx),
      .path_wr_byte  (path_wr_byte),
      .verdict       (verdict),
      .verdict_count (verdict_count)
   );

   always_comb begin
      out_free       = !out_valid_ff || rsp_chan.ready;
      req_chan.ready = (ctl_state_ff == CTL_PARSE) && out_free;
      accept         = req_chan.valid && req_chan.ready;
      start_replay   = accept && req_chan.line_end && verdict.status == ST_VALID &&
                       verdict_count != '0;
      load_direct    = accept && req_chan.line_end && !start_replay;
      load_byte      = 1'b0;
      load_final     = 1'b0;
      issue          = 1'b0;
      ctl_state_in   = ctl_state_ff;
      rd_idx_in      = rd_idx_ff;
      rd_pend_in     = rd_pend_ff;

      case (ctl_state_ff)
         CTL_PARSE: begin
            if (start_replay) begin
               ctl_state_in = CTL_REPLAY;
               rd_idx_in    = '0;
               rd_pend_in   = 1'b0;
            end
         end
         CTL_REPLAY: begin
            load_byte = rd_pend_ff && out_free;
            issue     = (rd_idx_ff != fin_cnt_ff) && (!rd_pend_ff || load_byte);
            if (issue) begin
               rd_idx_in  = rd_idx_ff + 1'b1;
               rd_pend_in = 1'b1;
            end else if (load_byte) begin
               rd_pend_in = 1'b0;
            end
            if (rd_idx_ff == fin_cnt_ff && (!rd_pend_ff || load_byte)) begin
               ctl_state_in = CTL_FINAL;
            end
         end
         CTL_FINAL: begin
            load_final = out_free;
            if (out_free) ctl_state_in = CTL_PARSE;
         end
         default: ctl_state_in = CTL_PARSE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_state_ff <= CTL_PARSE;
         rd_idx_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         ctl_state_ff <= ctl_state_in;
         rd_idx_ff    <= rd_idx_in;
         rd_pend_ff   <= rd_pend_in;
         if (load_direct || load_byte || load_final) out_valid_ff <= 1'b1;
         else if (rsp_chan.ready)                    out_valid_ff <= 1'b0;
      end
   end

   // path memory: one write port from the parser, one read port for replay
   always_ff @(posedge clock) begin
      if (path_wr_en) path_mem[path_wr_idx] <= path_wr_byte;
      if (issue)      rd_data_ff <= path_mem[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (start_replay) begin
         fin_sum_ff <= verdict.checksum;
         fin_cnt_ff <= verdict_count;
      end
      if (load_direct) begin
         out_char_ff   <= 8'd0;
         out_status_ff <= verdict.status;
         out_sum_ff    <= (verdict.status == ST_VALID) ? verdict.checksum : 32'd0;
         out_len_ff    <= (verdict.status == ST_VALID) ? 6'(verdict_count) : 6'd0;
         out_final_ff  <= 1'b1;
      end else if (load_byte) begin
         out_char_ff   <= rd_data_ff;
         out_status_ff <= ST_VALID;
         out_sum_ff    <= 32'd0;
         out_len_ff    <= 6'd0;
         out_final_ff  <= 1'b0;
      end else if (load_final) begin
         out_char_ff   <= 8'd0;
         out_status_ff <= ST_VALID;
         out_sum_ff    <= fin_sum_ff;
         out_len_ff    <= 6'(fin_cnt_ff);
         out_final_ff  <= 1'b1;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.path_char      = out_char_ff;
   assign rsp_chan.status         = out_status_ff;
   assign rsp_chan.checksum_value = out_sum_ff;
   assign rsp_chan.path_length    = out_len_ff;
   assign rsp_chan.final_flag     = out_final_ff;

   // replay read index never runs past the stored path length
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      ctl_state_ff == CTL_REPLAY |-> rd_idx_ff <= fin_cnt_ff)
      else $error("replay index beyond path length");

   // a pending read only exists while replaying
   a_pend_state: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> ctl_state_ff == CTL_REPLAY)
      else $error("read pending outside replay");

   // path byte beats come only from the replay
   a_path_src: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_final_ff |-> ctl_state_ff != CTL_PARSE)
      else $error("path beat outside replay");

   // non-valid finals carry no checksum or length
   a_fin_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_final_ff && out_status_ff != ST_VALID |->
         out_sum_ff == 32'd0 && out_len_ff == 6'd0)
      else $error("non-valid final with payload");

   // a line end beat that starts a replay keeps the input closed next cycle
   a_replay_hold: assert property (@(posedge clock) disable iff (reset)
      start_replay |=> !req_chan.ready)
      else $error("input open during replay");

endmodule

`default_nettype wire
